// ----- rtl/cha_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ChaCha keystream XOR block.
// Used by the interfaces, the block core and the top level.
package cha_pkg;

  localparam int BLOCK_BYTES    = 64;
  localparam int BYTES_PER_ITEM = 8;
  localparam int NUM_LANES      = 4;
  localparam int NUM_WORDS      = 16;
  localparam int POS_W          = $clog2(BLOCK_BYTES);
  localparam int CNT_W          = $clog2(BYTES_PER_ITEM + 1);
  localparam int DATA_W         = 8 * BYTES_PER_ITEM;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;

  localparam logic [31:0] SIGMA0 = 32'd1634760805;
  localparam logic [31:0] SIGMA1 = 32'd857760878;
  localparam logic [31:0] SIGMA2 = 32'd2036477234;
  localparam logic [31:0] SIGMA3 = 32'd1797285236;

  localparam logic [CFG_IDX_W-1:0] REG_KEY01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CTR     = 3'd7;

  localparam logic [4:0] ROUNDS_RESET = 5'd8;

  typedef logic [NUM_WORDS-1:0][31:0] word_arr_t;

  typedef struct packed {
    logic [63:0] key01;
    logic [63:0] key23;
    logic [63:0] key45;
    logic [63:0] key67;
    logic [63:0] nonce01;
    logic [31:0] nonce2;
    logic [4:0]  rounds;
    logic [31:0] ctr_start;
  } cha_cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ctr;
  } cha_core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cha_core_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROC,
    ST_GEN
  } cha_state_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_ADD
  } cha_core_state_t;

  function automatic word_arr_t cha_init(input cha_cfg_t cfg, input logic [31:0] ctr);
    word_arr_t w;
    w[0]  = SIGMA0;
    w[1]  = SIGMA1;
    w[2]  = SIGMA2;
    w[3]  = SIGMA3;
    w[4]  = cfg.key01[31:0];
    w[5]  = cfg.key01[63:32];
    w[6]  = cfg.key23[31:0];
    w[7]  = cfg.key23[63:32];
    w[8]  = cfg.key45[31:0];
    w[9]  = cfg.key45[63:32];
    w[10] = cfg.key67[31:0];
    w[11] = cfg.key67[63:32];
    w[12] = ctr;
    w[13] = cfg.nonce01[31:0];
    w[14] = cfg.nonce01[63:32];
    w[15] = cfg.nonce2;
    return w;
  endfunction

endpackage

// ----- rtl/cha_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the request and result channels.
// Depends on cha_pkg for payload widths.
interface cha_in_if import cha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              msg_start;
  logic [DATA_W-1:0] data_in;
  logic [3:0]        byte_count;

  modport source (output valid, msg_start, data_in, byte_count, input ready);
  modport sink   (input valid, msg_start, data_in, byte_count, output ready);
endinterface

interface cha_out_if import cha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_out;
  logic [3:0]        out_count;

  modport source (output valid, data_out, out_count, input ready);
  modport sink   (input valid, data_out, out_count, output ready);
endinterface

// ----- rtl/cha_qr.sv -----
`timescale 1ns / 1ps
// One ChaCha quarter-round lane, purely combinational.
// Depends on nothing beyond the timescale.
module cha_qr (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2, x;

  always_comb begin
    a1  = a_i + b_i;
    x   = d_i ^ a1;
    d1  = {x[15:0], x[31:16]};
    c1  = c_i + d1;
    x   = b_i ^ c1;
    b1  = {x[19:0], x[31:20]};
    a2  = a1 + b1;
    x   = d1 ^ a2;
    d2  = {x[23:0], x[31:24]};
    c2  = c1 + d2;
    x   = b1 ^ c2;
    b2  = {x[24:0], x[31:25]};
  end

  assign a_o = a2;
  assign b_o = b2;
  assign c_o = c2;
  assign d_o = d2;

endmodule

// ----- rtl/cha_core.sv -----
`timescale 1ns / 1ps
// Block core: four quarter-round lanes run one half round per cycle,
// then the input state is added back. Depends on cha_pkg and cha_qr.
module cha_core import cha_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cha_cfg_t      cfg,
  input  cha_core_req_t req,
  output cha_core_sts_t sts,
  output word_arr_t     ks_block
);

  cha_core_state_t cst_r, cst_nxt;
  word_arr_t       work_r, work_nxt;
  word_arr_t       ks_r;
  word_arr_t       init_w;
  logic [31:0]     ctr_r;
  logic [5:0]      left_r, left_nxt;
  logic            diag_r, diag_nxt;
  logic            done_r;
  logic [4:0]      doubles;

  logic [NUM_LANES-1:0][31:0] la, lb, lc, ld, oa, ob, oc, od;

  assign doubles = 5'(({1'b0, cfg.rounds} + 6'd1) >> 1);

  // Input state of the block in flight, added back at the end.
  assign init_w = cha_init(cfg, ctr_r);

  // Lane input selection: columns on even half rounds, diagonals on odd.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam int IB = 4 + ((l + 1) % 4);
    localparam int IC = 8 + ((l + 2) % 4);
    localparam int ID = 12 + ((l + 3) % 4);
    assign la[l] = work_r[l];
    assign lb[l] = diag_r ? work_r[IB] : work_r[4 + l];
    assign lc[l] = diag_r ? work_r[IC] : work_r[8 + l];
    assign ld[l] = diag_r ? work_r[ID] : work_r[12 + l];
    cha_qr u_qr (
      .a_i(la[l]), .b_i(lb[l]), .c_i(lc[l]), .d_i(ld[l]),
      .a_o(oa[l]), .b_o(ob[l]), .c_o(oc[l]), .d_o(od[l])
    );
  end

  always_comb begin
    cst_nxt = cst_r;
    case (cst_r)
      CORE_IDLE: if (req.start) cst_nxt = CORE_RUN;
      CORE_RUN:  if (left_r == 6'd0) cst_nxt = CORE_ADD;
      CORE_ADD:  cst_nxt = CORE_IDLE;
      default:   cst_nxt = CORE_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = (cst_r != CORE_IDLE);
    sts.done = done_r;
  end

  // Merge stage: lane results go back to the words they came from.
  always_comb begin
    work_nxt = work_r;
    left_nxt = left_r;
    diag_nxt = diag_r;
    case (cst_r)
      CORE_IDLE: begin
        work_nxt = cha_init(cfg, req.ctr);
        left_nxt = {doubles, 1'b0};
        diag_nxt = 1'b0;
      end
      CORE_RUN: begin
        if (left_r != 6'd0) begin
          for (int l = 0; l < NUM_LANES; l++) begin
            work_nxt[l] = oa[l];
            if (diag_r) begin
              work_nxt[4 + ((l + 1) % 4)]  = ob[l];
              work_nxt[8 + ((l + 2) % 4)]  = oc[l];
              work_nxt[12 + ((l + 3) % 4)] = od[l];
            end else begin
              work_nxt[4 + l]  = ob[l];
              work_nxt[8 + l]  = oc[l];
              work_nxt[12 + l] = od[l];
            end
          end
          left_nxt = left_r - 6'd1;
          diag_nxt = ~diag_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r  <= CORE_IDLE;
      done_r <= 1'b0;
    end else begin
      cst_r  <= cst_nxt;
      done_r <= (cst_r == CORE_ADD);
    end
    work_r <= work_nxt;
    left_r <= left_nxt;
    diag_r <= diag_nxt;
    if (cst_r == CORE_IDLE && req.start) ctr_r <= req.ctr;
    if (cst_r == CORE_ADD) begin
      for (int i = 0; i < NUM_WORDS; i++) ks_r[i] <= work_r[i] + init_w[i];
    end
  end

  assign ks_block = ks_r;

endmodule

// ----- rtl/chacha_keystream_xor.sv -----
`timescale 1ns / 1ps
// Top level of the ChaCha keystream XOR block; depends on cha_pkg, cha_if
// and cha_core (which holds four cha_qr lanes).
//
// This block XORs a message, eight bytes per request, with a ChaCha
// keystream in the IETF layout (256-bit key, 96-bit nonce, 32-bit block
// counter that wraps). Key, nonce, round count and starting counter must be
// set through the write port while the block is idle; the block does not
// enforce this. A request with msg_start restarts the keystream at the
// starting counter. A request that draws on bytes from the current
// keystream block is accepted, then up to eight bytes are XORed and the
// output register loaded when it is free. When a request needs a fresh
// 64-byte block, the four quarter-round lanes finish one half round per
// cycle, then the input state is added back, the done flag is registered
// and the bytes are taken in the processing state. A block boundary may
// fall inside a request; the block is then finished, a new one made, and
// the rest of the bytes taken from it. Bytes beyond byte_count come out as
// zero, and a byte_count above eight is treated as eight. A new request is
// accepted while the previous result still waits in the output register.

module chacha_keystream_xor import cha_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  cha_in_if.sink                in_ch,
  cha_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cha_cfg_t      cfg_r;
  cha_state_t    st_r, st_nxt;
  cha_core_req_t core_req;
  cha_core_sts_t core_sts;
  word_arr_t     ks_block;
  logic [8*BLOCK_BYTES-1:0] ks_flat;

  logic [31:0]       bctr_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              bvalid_r, bvalid_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_in;
  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic [POS_W:0]    avail, take, pos_sum;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [3:0]        out_count_r;
  logic              slot_free, in_take, out_load, gen_start;

  assign ks_flat = ks_block;

  // Requested byte count, clamped to eight.
  assign cnt_in = (in_ch.byte_count > 4'(BYTES_PER_ITEM)) ?
                  CNT_W'(BYTES_PER_ITEM) : CNT_W'(in_ch.byte_count);

  assign slot_free = !out_valid_r || out_ch.ready;

  // Bytes that the current block can still give to this request.
  always_comb begin
    avail   = 7'(BLOCK_BYTES) - {1'b0, pos_r};
    take    = 7'd0;
    if (bvalid_r) take = ({3'd0, rem_r} < avail) ? {3'd0, rem_r} : avail;
    pos_sum = {1'b0, pos_r} + take;
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_ch.valid) st_nxt = ST_PROC;
      ST_PROC: begin
        if (rem_r == CNT_W'(take)) begin
          if (slot_free) st_nxt = ST_IDLE;
        end else begin
          st_nxt = ST_GEN;
        end
      end
      ST_GEN:  if (core_sts.done) st_nxt = ST_PROC;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Handshake and core control.
  always_comb begin
    in_take   = 1'b0;
    out_load  = 1'b0;
    gen_start = 1'b0;
    case (st_r)
      ST_IDLE: in_take = in_ch.valid;
      ST_PROC: begin
        if (rem_r == CNT_W'(take)) out_load = slot_free;
        else                       gen_start = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ch.ready    = (st_r == ST_IDLE);
  assign core_req.start = gen_start;
  assign core_req.ctr   = bctr_r;

  // XOR stage: byte j of the request takes block byte pos + (j - done).
  always_comb begin
    logic [CNT_W-1:0] off;
    logic [POS_W-1:0] idx;
    res_nxt    = res_r;
    pos_nxt    = pos_r;
    bvalid_nxt = bvalid_r;
    rem_nxt    = rem_r - CNT_W'(take);
    done_nxt   = done_r + CNT_W'(take);
    for (int j = 0; j < BYTES_PER_ITEM; j++) begin
      off = CNT_W'(j) - done_r;
      idx = pos_r + POS_W'(off);
      if (CNT_W'(j) >= done_r && {3'd0, off} < take) begin
        res_nxt[8*j +: 8] = data_r[8*j +: 8] ^ ks_flat[8*idx +: 8];
      end
    end
    pos_nxt = pos_sum[POS_W-1:0];
    if (pos_sum[POS_W]) bvalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_IDLE;
      bctr_r        <= 32'd0;
      pos_r         <= '0;
      bvalid_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      cfg_r         <= '0;
      cfg_r.rounds  <= ROUNDS_RESET;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY01:   cfg_r.key01     <= cfg_data;
          REG_KEY23:   cfg_r.key23     <= cfg_data;
          REG_KEY45:   cfg_r.key45     <= cfg_data;
          REG_KEY67:   cfg_r.key67     <= cfg_data;
          REG_NONCE01: cfg_r.nonce01   <= cfg_data;
          REG_NONCE2:  cfg_r.nonce2    <= cfg_data[31:0];
          REG_ROUNDS:  cfg_r.rounds    <= cfg_data[4:0];
          REG_CTR:     cfg_r.ctr_start <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_take && in_ch.msg_start) begin
        bctr_r   <= cfg_r.ctr_start;
        pos_r    <= '0;
        bvalid_r <= 1'b0;
      end else if (st_r == ST_PROC) begin
        pos_r    <= pos_nxt;
        bvalid_r <= bvalid_nxt;
        if (gen_start) bctr_r <= bctr_r + 32'd1;
      end else if (st_r == ST_GEN && core_sts.done) begin
        pos_r    <= '0;
        bvalid_r <= 1'b1;
      end
      if (out_load)               out_valid_r <= 1'b1;
      else if (out_ch.ready)      out_valid_r <= 1'b0;
    end
    if (in_take) begin
      data_r <= in_ch.data_in;
      cnt_r  <= cnt_in;
      rem_r  <= cnt_in;
      done_r <= '0;
      res_r  <= '0;
    end else if (st_r == ST_PROC) begin
      rem_r  <= rem_nxt;
      done_r <= done_nxt;
      res_r  <= res_nxt;
    end
    if (out_load) begin
      out_data_r  <= res_nxt;
      out_count_r <= 4'(cnt_r);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_out  = out_data_r;
  assign out_ch.out_count = out_count_r;

  cha_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .req      (core_req),
    .sts      (core_sts),
    .ks_block (ks_block)
  );

endmodule
